// ----- rtl/core/mm4_pkg.sv -----
// shared constants, types and helpers for the 4x4 fixed point matrix multiplier
`timescale 1ns / 1ps
`default_nettype none

package mm4_pkg;

   localparam int MATRIX_SIZE   = 4;
   localparam int FRACTION_BITS = 16;
   localparam int CELLS         = MATRIX_SIZE * MATRIX_SIZE;
   localparam int IDX_W         = $clog2(MATRIX_SIZE);
   localparam int ADDR_W        = $clog2(CELLS);
   localparam int ACTION_W      = 2;
   localparam int VALUE_W       = 32;
   localparam int PROD_W        = 2 * VALUE_W;
   localparam int ACC_W         = PROD_W + IDX_W;

   typedef logic [IDX_W-1:0]           idx_type;
   typedef logic [ADDR_W-1:0]          addr_type;
   typedef logic [ACTION_W-1:0]        action_type;
   typedef logic signed [VALUE_W-1:0]  value_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [ACC_W-1:0]    acc_type;

   localparam action_type ACT_LOAD_LEFT  = 2'd0;
   localparam action_type ACT_LOAD_RIGHT = 2'd1;
   localparam action_type ACT_COMPUTE    = 2'd2;

   localparam idx_type   IDX_MAX   = idx_type'(MATRIX_SIZE - 1);
   localparam value_type VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam value_type VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   // control that travels with each product through the pipeline
   typedef struct packed {
      logic    first;
      logic    last_k;
      idx_type row;
      idx_type col;
   } tag_type;

   // row-major element address
   function automatic addr_type cell_addr(input idx_type r, input idx_type c);
      return addr_type'(int'(r) * MATRIX_SIZE + int'(c));
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mm4_ram.sv -----
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module mm4_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/matrix4_multiply.sv -----
// top level of the 4x4 signed fixed point matrix multiplier
//
// channel   ports                                   handshake
// request   req_action req_row req_col req_value    start, taken when busy is low
// response  rsp_out_row rsp_out_col rsp_out_value   rsp_valid, one cycle, no stall
//           rsp_saturated rsp_last
//
// a load request writes its ram and busy stays low
// a compute request runs 64 multiply-accumulates on one shared
// multiplier, one per cycle, through the ram read, product, sum and output registers
// one response comes per element, column by column; busy falls with the last one
// synchronous reset clears the sequencer; matrix contents are kept
`timescale 1ns / 1ps
`default_nettype none

module matrix4_multiply (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire mm4_pkg::action_type        req_action,
   input  wire mm4_pkg::idx_type           req_row,
   input  wire mm4_pkg::idx_type           req_col,
   input  wire mm4_pkg::value_type         req_value,
   output logic                            rsp_valid,
   output mm4_pkg::idx_type                rsp_out_row,
   output mm4_pkg::idx_type                rsp_out_col,
   output mm4_pkg::value_type              rsp_out_value,
   output logic                            rsp_saturated,
   output logic                            rsp_last
);

   logic                  accept;
   logic                  wr_left;
   logic                  wr_right;
   mm4_pkg::addr_type     wr_addr;
   mm4_pkg::addr_type     left_rd_addr;
   mm4_pkg::addr_type     right_rd_addr;
   mm4_pkg::value_type    left_rd_data;
   mm4_pkg::value_type    right_rd_data;

   // sequencer
   logic                  busy_ff,    busy_in;
   logic                  issue_ff,   issue_in;
   mm4_pkg::idx_type      k_ff,       k_in;
   mm4_pkg::idx_type      r_ff,       r_in;
   mm4_pkg::idx_type      c_ff,       c_in;

   // pipeline
   logic                  s1_valid_ff, s1_valid_in;
   mm4_pkg::tag_type      s1_tag_ff,   s1_tag_in;
   logic                  s2_valid_ff, s2_valid_in;
   mm4_pkg::tag_type      s2_tag_ff,   s2_tag_in;
   mm4_pkg::prod_type     product_ff,  product_in;
   logic                  acc_done_ff, acc_done_in;
   mm4_pkg::tag_type      acc_tag_ff,  acc_tag_in;
   mm4_pkg::acc_type      acc_ff,      acc_in;

   // output
   logic                  out_valid_ff, out_valid_in;
   mm4_pkg::idx_type      out_row_ff,   out_row_in;
   mm4_pkg::idx_type      out_col_ff,   out_col_in;
   mm4_pkg::value_type    out_value_ff, out_value_in;
   logic                  out_sat_ff,   out_sat_in;
   logic                  out_last_ff,  out_last_in;

   mm4_pkg::acc_type      shifted;
   logic                  fits;
   logic                  final_elem;

   assign accept   = start && !busy_ff;
   assign wr_left  = accept && (req_action == mm4_pkg::ACT_LOAD_LEFT);
   assign wr_right = accept && (req_action == mm4_pkg::ACT_LOAD_RIGHT);
   assign wr_addr  = mm4_pkg::cell_addr(req_row, req_col);

   assign left_rd_addr  = mm4_pkg::cell_addr(r_ff, k_ff);
   assign right_rd_addr = mm4_pkg::cell_addr(k_ff, c_ff);

   mm4_ram #(
      .WIDTH(mm4_pkg::VALUE_W),
      .DEPTH(mm4_pkg::CELLS)
   ) u_left_ram (
      .clock  (clock),
      .wr_en  (wr_left),
      .wr_addr(wr_addr),
      .wr_data(req_value),
      .rd_addr(left_rd_addr),
      .rd_data(left_rd_data)
   );

   mm4_ram #(
      .WIDTH(mm4_pkg::VALUE_W),
      .DEPTH(mm4_pkg::CELLS)
   ) u_right_ram (
      .clock  (clock),
      .wr_en  (wr_right),
      .wr_addr(wr_addr),
      .wr_data(req_value),
      .rd_addr(right_rd_addr),
      .rd_data(right_rd_data)
   );

   // sequencer: k fastest, then row, then column
   always_comb begin
      issue_in = issue_ff;
      k_in     = k_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      if (accept && (req_action == mm4_pkg::ACT_COMPUTE)) begin
         issue_in = 1'b1;
         k_in     = '0;
         r_in     = '0;
         c_in     = '0;
      end else if (issue_ff) begin
         k_in = mm4_pkg::idx_type'(k_ff + 1'b1);
         if (k_ff == mm4_pkg::IDX_MAX) begin
            k_in = '0;
            r_in = mm4_pkg::idx_type'(r_ff + 1'b1);
            if (r_ff == mm4_pkg::IDX_MAX) begin
               r_in = '0;
               c_in = mm4_pkg::idx_type'(c_ff + 1'b1);
               if (c_ff == mm4_pkg::IDX_MAX) begin
                  c_in     = '0;
                  issue_in = 1'b0;
               end
            end
         end
      end
   end

   // pipeline stages: ram read, product, accumulate
   always_comb begin
      s1_valid_in      = issue_ff;
      s1_tag_in.first  = (k_ff == '0);
      s1_tag_in.last_k = (k_ff == mm4_pkg::IDX_MAX);
      s1_tag_in.row    = r_ff;
      s1_tag_in.col    = c_ff;

      s2_valid_in = s1_valid_ff;
      s2_tag_in   = s1_tag_ff;
      product_in  = mm4_pkg::prod_type'(left_rd_data) * mm4_pkg::prod_type'(right_rd_data);

      acc_done_in = s2_valid_ff && s2_tag_ff.last_k;
      acc_tag_in  = s2_tag_ff;
      acc_in      = acc_ff;
      if (s2_valid_ff) begin
         if (s2_tag_ff.first) begin
            acc_in = mm4_pkg::acc_type'(product_ff);
         end else begin
            acc_in = acc_ff + mm4_pkg::acc_type'(product_ff);
         end
      end
   end

   // truncate and saturate, and update busy
   always_comb begin
      shifted    = acc_ff >>> mm4_pkg::FRACTION_BITS;
      fits       = (shifted[mm4_pkg::ACC_W-1:mm4_pkg::VALUE_W-1] == '0) ||
                   (shifted[mm4_pkg::ACC_W-1:mm4_pkg::VALUE_W-1] == '1);
      final_elem = (acc_tag_ff.row == mm4_pkg::IDX_MAX) &&
                   (acc_tag_ff.col == mm4_pkg::IDX_MAX);

      out_valid_in = acc_done_ff;
      out_row_in   = acc_tag_ff.row;
      out_col_in   = acc_tag_ff.col;
      out_last_in  = final_elem;
      out_sat_in   = !fits;
      if (fits) begin
         out_value_in = shifted[mm4_pkg::VALUE_W-1:0];
      end else if (acc_ff[mm4_pkg::ACC_W-1]) begin
         out_value_in = mm4_pkg::VALUE_MIN;
      end else begin
         out_value_in = mm4_pkg::VALUE_MAX;
      end

      busy_in = busy_ff;
      if (accept && (req_action == mm4_pkg::ACT_COMPUTE)) begin
         busy_in = 1'b1;
      end else if (acc_done_ff && final_elem) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         issue_ff     <= 1'b0;
         k_ff         <= '0;
         r_ff         <= '0;
         c_ff         <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         acc_done_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         issue_ff     <= issue_in;
         k_ff         <= k_in;
         r_ff         <= r_in;
         c_ff         <= c_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         acc_done_ff  <= acc_done_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_tag_ff    <= s1_tag_in;
      s2_tag_ff    <= s2_tag_in;
      product_ff   <= product_in;
      acc_tag_ff   <= acc_tag_in;
      acc_ff       <= acc_in;
      out_row_ff   <= out_row_in;
      out_col_ff   <= out_col_in;
      out_value_ff <= out_value_in;
      out_sat_ff   <= out_sat_in;
      out_last_ff  <= out_last_in;
   end

   assign busy          = busy_ff;
   assign rsp_valid     = out_valid_ff;
   assign rsp_out_row   = out_row_ff;
   assign rsp_out_col   = out_col_ff;
   assign rsp_out_value = out_value_ff;
   assign rsp_saturated = out_sat_ff;
   assign rsp_last      = out_last_ff;

endmodule

`default_nettype wire

// ----- verif/tb_matrix4_multiply.sv -----
// self-checking testbench for the 4x4 fixed point matrix multiplier
`timescale 1ns / 1ps

module tb_matrix4_multiply;

   localparam mm4_pkg::action_type ACT_UNUSED     = 2'd3;
   localparam int                  ITEM_COUNT     = 67;
   localparam int                  WATCHDOG_LIMIT = 1000;
   localparam int                  DRAIN_CYCLES   = 20;
   localparam int                  SUM_W          = 68;

   typedef struct {
      mm4_pkg::idx_type   row;
      mm4_pkg::idx_type   col;
      mm4_pkg::value_type value;
      logic               sat;
      logic               last;
   } product_type;

   class product_board;
      mm4_pkg::value_type left_m [mm4_pkg::CELLS];
      mm4_pkg::value_type right_m [mm4_pkg::CELLS];
      product_type        pending [$];
      int                 errors = 0;

      function void note_request(mm4_pkg::action_type action, mm4_pkg::idx_type row,
                                 mm4_pkg::idx_type col, mm4_pkg::value_type value);
         logic signed [SUM_W-1:0] acc;
         logic signed [SUM_W-1:0] shifted;
         product_type             p;
         case (action)
            mm4_pkg::ACT_LOAD_LEFT: begin
               left_m[row * mm4_pkg::MATRIX_SIZE + col] = value;
            end
            mm4_pkg::ACT_LOAD_RIGHT: begin
               right_m[row * mm4_pkg::MATRIX_SIZE + col] = value;
            end
            mm4_pkg::ACT_COMPUTE: begin
               for (int c = 0; c < mm4_pkg::MATRIX_SIZE; c++) begin
                  for (int r = 0; r < mm4_pkg::MATRIX_SIZE; r++) begin
                     acc = '0;
                     for (int k = 0; k < mm4_pkg::MATRIX_SIZE; k++) begin
                        acc = acc + left_m[r * mm4_pkg::MATRIX_SIZE + k] *
                                    right_m[k * mm4_pkg::MATRIX_SIZE + c];
                     end
                     // floor shift, then clip to 32 bits
                     shifted = acc >>> mm4_pkg::FRACTION_BITS;
                     p.row   = mm4_pkg::idx_type'(r);
                     p.col   = mm4_pkg::idx_type'(c);
                     p.last  = (r == mm4_pkg::MATRIX_SIZE - 1) &&
                               (c == mm4_pkg::MATRIX_SIZE - 1);
                     if (shifted > SUM_W'(mm4_pkg::VALUE_MAX)) begin
                        p.value = mm4_pkg::VALUE_MAX;
                        p.sat   = 1'b1;
                     end else if (shifted < SUM_W'(mm4_pkg::VALUE_MIN)) begin
                        p.value = mm4_pkg::VALUE_MIN;
                        p.sat   = 1'b1;
                     end else begin
                        p.value = mm4_pkg::value_type'(shifted);
                        p.sat   = 1'b0;
                     end
                     pending.push_back(p);
                  end
               end
            end
            default: begin
            end
         endcase
      endfunction

      function void check_response(mm4_pkg::idx_type row, mm4_pkg::idx_type col,
                                   mm4_pkg::value_type value, logic sat, logic last);
         product_type want;
         if (pending.size() == 0) begin
            $error("unexpected response: out_row %0d out_col %0d out_value %h",
                   row, col, value);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (row !== want.row) begin
            $error("out_row: expected %0d actual %0d", want.row, row);
            errors++;
         end
         if (col !== want.col) begin
            $error("out_col: expected %0d actual %0d", want.col, col);
            errors++;
         end
         if (value !== want.value) begin
            $error("out_value: expected %h actual %h", want.value, value);
            errors++;
         end
         if (sat !== want.sat) begin
            $error("saturated: expected %b actual %b", want.sat, sat);
            errors++;
         end
         if (last !== want.last) begin
            $error("last: expected %b actual %b", want.last, last);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending.size();
      endfunction
   endclass

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                start      = 1'b0;
   mm4_pkg::action_type req_action = mm4_pkg::ACT_LOAD_LEFT;
   mm4_pkg::idx_type    req_row    = '0;
   mm4_pkg::idx_type    req_col    = '0;
   mm4_pkg::value_type  req_value  = '0;
   logic                busy;
   logic                rsp_valid;
   mm4_pkg::idx_type    rsp_out_row;
   mm4_pkg::idx_type    rsp_out_col;
   mm4_pkg::value_type  rsp_out_value;
   logic                rsp_saturated;
   logic                rsp_last;

   product_board board = new;
   int           quiet_cycles = 0;

   matrix4_multiply i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_action    (req_action),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_value (rsp_out_value),
      .rsp_saturated (rsp_saturated),
      .rsp_last      (rsp_last)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic mm4_pkg::value_type pick_value();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 5))
               0: return mm4_pkg::VALUE_MIN;
               1: return mm4_pkg::VALUE_MAX;
               2: return '0;
               3: return -1;
               4: return 1;
               default: return mm4_pkg::value_type'(1 << mm4_pkg::FRACTION_BITS);
            endcase
         end
         1, 2: return mm4_pkg::value_type'($urandom);
         3, 4, 5: return mm4_pkg::value_type'($urandom_range(0, (1 << 18) - 1)) -
                         mm4_pkg::value_type'(1 << 17);
         default: return mm4_pkg::value_type'($urandom_range(0, (1 << 25) - 1)) -
                         mm4_pkg::value_type'(1 << 24);
      endcase
   endfunction

   // present one request, hold it until taken, then record it
   task automatic send_request(mm4_pkg::action_type action, mm4_pkg::idx_type row,
                               mm4_pkg::idx_type col, mm4_pkg::value_type value,
                               bit may_idle);
      int gap;
      gap = 0;
      while (may_idle && $urandom_range(0, 99) < 17) begin
         gap++;
      end
      if (gap > 0) begin
         start      <= 1'b0;
         req_action <= mm4_pkg::action_type'($urandom);
         req_row    <= mm4_pkg::idx_type'($urandom);
         req_col    <= mm4_pkg::idx_type'($urandom);
         req_value  <= mm4_pkg::value_type'($urandom);
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_action <= action;
      req_row    <= row;
      req_col    <= col;
      req_value  <= value;
      do @(posedge clock); while (busy !== 1'b0);
      board.note_request(action, row, col, value);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         board.check_response(rsp_out_row, rsp_out_col, rsp_out_value, rsp_saturated,
                              rsp_last);
      end
   end

   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int                  pick;
      mm4_pkg::action_type action;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // every element written before the first compute
      for (int r = 0; r < mm4_pkg::MATRIX_SIZE; r++) begin
         for (int c = 0; c < mm4_pkg::MATRIX_SIZE; c++) begin
            send_request(mm4_pkg::ACT_LOAD_LEFT, mm4_pkg::idx_type'(r),
                         mm4_pkg::idx_type'(c), pick_value(), 1'b1);
         end
      end
      for (int r = 0; r < mm4_pkg::MATRIX_SIZE; r++) begin
         for (int c = 0; c < mm4_pkg::MATRIX_SIZE; c++) begin
            send_request(mm4_pkg::ACT_LOAD_RIGHT, mm4_pkg::idx_type'(r),
                         mm4_pkg::idx_type'(c), pick_value(), 1'b1);
         end
      end

      send_request(mm4_pkg::ACT_COMPUTE, 2'd0, 2'd0, pick_value(), 1'b1);
      // clip high on the first element
      send_request(mm4_pkg::ACT_LOAD_LEFT, 2'd0, 2'd0, mm4_pkg::VALUE_MIN, 1'b1);
      send_request(mm4_pkg::ACT_LOAD_LEFT, 2'd0, 2'd1, '0, 1'b1);
      send_request(mm4_pkg::ACT_LOAD_LEFT, 2'd0, 2'd2, '0, 1'b1);
      send_request(mm4_pkg::ACT_LOAD_LEFT, 2'd0, 2'd3, '0, 1'b1);
      send_request(mm4_pkg::ACT_LOAD_RIGHT, 2'd0, 2'd0, mm4_pkg::VALUE_MIN, 1'b1);
      send_request(mm4_pkg::ACT_COMPUTE, 2'd3, 2'd3, mm4_pkg::VALUE_MAX, 1'b1);
      // clip low
      send_request(mm4_pkg::ACT_LOAD_RIGHT, 2'd0, 2'd0, mm4_pkg::VALUE_MAX, 1'b1);
      send_request(mm4_pkg::ACT_COMPUTE, 2'd1, 2'd2, mm4_pkg::VALUE_MIN, 1'b1);
      // unused action code changes nothing
      send_request(ACT_UNUSED, 2'd3, 2'd3, mm4_pkg::VALUE_MAX, 1'b1);
      send_request(ACT_UNUSED, 2'd0, 2'd0, mm4_pkg::VALUE_MIN, 1'b1);
      // floor of a tiny negative sum
      send_request(mm4_pkg::ACT_LOAD_LEFT, 2'd1, 2'd0, -1, 1'b1);
      send_request(mm4_pkg::ACT_LOAD_LEFT, 2'd1, 2'd1, '0, 1'b1);
      send_request(mm4_pkg::ACT_LOAD_LEFT, 2'd1, 2'd2, '0, 1'b1);
      send_request(mm4_pkg::ACT_LOAD_LEFT, 2'd1, 2'd3, '0, 1'b1);
      send_request(mm4_pkg::ACT_LOAD_RIGHT, 2'd0, 2'd1, 1, 1'b1);
      send_request(mm4_pkg::ACT_COMPUTE, 2'd0, 2'd0, '0, 1'b1);
      send_request(mm4_pkg::ACT_LOAD_LEFT, 2'd3, 2'd3, mm4_pkg::VALUE_MAX, 1'b1);
      send_request(mm4_pkg::ACT_LOAD_RIGHT, 2'd3, 2'd3, mm4_pkg::VALUE_MAX, 1'b1);
      send_request(mm4_pkg::ACT_COMPUTE, 2'd2, 2'd1, -1, 1'b1);

      for (int i = 0; i < ITEM_COUNT; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 44) begin
            action = mm4_pkg::ACT_LOAD_LEFT;
         end else if (pick < 88) begin
            action = mm4_pkg::ACT_LOAD_RIGHT;
         end else if (pick < 97) begin
            action = mm4_pkg::ACT_COMPUTE;
         end else begin
            action = ACT_UNUSED;
         end
         // a burst with no idling in the middle
         send_request(action, mm4_pkg::idx_type'($urandom), mm4_pkg::idx_type'($urandom),
                      pick_value(), !(i >= 30 && i < 60));
      end
      send_request(mm4_pkg::ACT_COMPUTE, 2'd0, 2'd0, pick_value(), 1'b0);
      start <= 1'b0;

      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/mm4_pkg.sv
rtl/core/mm4_ram.sv
rtl/core/matrix4_multiply.sv
verif/tb_matrix4_multiply.sv
